>>> rtl/blled_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery LED gauge package
// Shared widths, codes and small helper functions for the LED bar gauge.
// ----------------------------------------------------------------------------
package blled_pkg;

  localparam int WindowWidth = 16;
  localparam int LevelWidth  = 7;
  localparam int SocWidth    = 16;
  localparam int CfgWidth    = 16;
  localparam int NumLeds     = 4;

  localparam logic [LevelWidth-1:0]  LevelMax  = LevelWidth'(100);
  localparam logic [7:0]             SaveTag   = 8'h5A;
  localparam logic [WindowWidth-1:0] WindowMax = {WindowWidth{1'b1}};

  typedef enum logic [2:0] {
    CmdService   = 3'd0,
    CmdWindow    = 3'd1,
    CmdPrepStop  = 3'd2,
    CmdPreview   = 3'd3,
    CmdSleep     = 3'd4,
    CmdWake      = 3'd5,
    CmdSave      = 3'd6
  } cmd_e;

  typedef enum logic [2:0] {
    RegDisplayWindow = 3'd0,
    RegStartupWindow = 3'd1,
    RegThresholdOne  = 3'd2,
    RegThresholdTwo  = 3'd3,
    RegThresholdThr  = 3'd4,
    RegThresholdFour = 3'd5
  } reg_idx_e;

  typedef logic [WindowWidth-1:0] window_t;
  typedef logic [LevelWidth-1:0]  level_t;

  // Clamp a raw charge reading to the 0..100 range.
  function automatic level_t clamp_level(input logic [SocWidth-1:0] soc);
    level_t res;
    if (soc > SocWidth'(LevelMax)) begin
      res = LevelMax;
    end else begin
      res = soc[LevelWidth-1:0];
    end
    return res;
  endfunction

  // Raise the window count to a length, saturating the length first.
  function automatic window_t raise_window(input window_t cur,
                                           input logic [CfgWidth-1:0] len);
    window_t len_sat;
    window_t res;
    if (CfgWidth'(len) > CfgWidth'(WindowMax)) begin
      len_sat = WindowMax;
    end else begin
      len_sat = WindowWidth'(len);
    end
    res = (cur < len_sat) ? len_sat : cur;
    return res;
  endfunction

endpackage

>>> rtl/battery_level_led_bar_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery level LED bar controller
// Four-LED thermometer gauge with display window, sleep and level backup.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the slave stream carries one command in tuser and the
//   switch, key, tick and charge levels in tdata. Every request yields one
//   result on the master stream: the LED mask, the low-power activity flag
//   and the deep-sleep pulse.
//   A request accepted at an edge has its result on the master side from
//   that edge on. The whole update is one pass through short logic into
//   the result register, so throughput is one request per cycle while the
//   receiver does not stall.
//   The slave side stays ready while the result register is empty or is
//   being drained in the same cycle; when the receiver stalls, the result
//   holds and the slave side stalls with it, so nothing is lost.
//   Reset restores the register defaults (windows 300 and 1000 ticks,
//   thresholds 1, 26, 51, 76), blanks the gauge and empties the result
//   register. Configuration writes take effect at the next edge and are
//   meant for idle periods only.
// ----------------------------------------------------------------------------
module battery_level_led_bar_controller
  import blled_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [CfgWidth-1:0] cfg_data_i,
  // request stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: tick_10ms, key_pressed, main_switch_closed, charge_active,
  //        soc_raw[15:0], zero pad
  input  logic [23:0]         s_axis_tdata,
  // tuser: cmd[2:0]
  input  logic [2:0]          s_axis_tuser,
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: led_mask[3:0], active_for_low_power, enter_deep_sleep, zero pad
  output logic [7:0]          m_axis_tdata
);

  // configuration registers
  window_t dwin_q, swin_q;
  level_t  thr_q [NumLeds];

  // gauge state
  logic    asleep_q, asleep_d;
  logic    blanked_q, blanked_d;
  level_t  shown_q, shown_d;
  window_t win_q, win_d;
  logic    startup_q, startup_d;
  logic    key_q, key_d;
  logic    swsleep_q, swsleep_d;
  logic [SocWidth-1:0] sword_q, sword_d;
  logic [SocWidth-1:0] sinv_q, sinv_d;

  // result register
  logic       out_valid_q;
  logic [7:0] out_data_q, out_data_d;

  logic accept;

  // request fields
  logic                tick, key, closed, charging;
  logic [SocWidth-1:0] soc;
  level_t              soc_lvl;

  assign tick     = s_axis_tdata[0];
  assign key      = s_axis_tdata[1];
  assign closed   = s_axis_tdata[2];
  assign charging = s_axis_tdata[3];
  assign soc      = s_axis_tdata[19:4];
  assign soc_lvl  = clamp_level(soc);

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Configuration writes; out-of-range indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dwin_q   <= WindowWidth'(300);
      swin_q   <= WindowWidth'(1000);
      thr_q[0] <= LevelWidth'(1);
      thr_q[1] <= LevelWidth'(26);
      thr_q[2] <= LevelWidth'(51);
      thr_q[3] <= LevelWidth'(76);
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        RegDisplayWindow: dwin_q   <= cfg_data_i;
        RegStartupWindow: swin_q   <= cfg_data_i;
        RegThresholdOne:  thr_q[0] <= cfg_data_i[LevelWidth-1:0];
        RegThresholdTwo:  thr_q[1] <= cfg_data_i[LevelWidth-1:0];
        RegThresholdThr:  thr_q[2] <= cfg_data_i[LevelWidth-1:0];
        RegThresholdFour: thr_q[3] <= cfg_data_i[LevelWidth-1:0];
        default: ;
      endcase
    end
  end

  // One pass of the gauge update for the request on the slave side.
  always_comb begin
    logic   pulse;
    logic   active;
    logic   valid_save;
    logic [NumLeds-1:0] mask;

    asleep_d  = asleep_q;
    blanked_d = blanked_q;
    shown_d   = shown_q;
    win_d     = win_q;
    startup_d = startup_q;
    key_d     = key_q;
    swsleep_d = swsleep_q;
    sword_d   = sword_q;
    sinv_d    = sinv_q;
    pulse     = 1'b0;

    // The backup pair is trusted only when intact, tagged and in range.
    valid_save = ((sword_q ^ sinv_q) == {SocWidth{1'b1}}) &&
                 (sword_q[15:8] == SaveTag) &&
                 (sword_q[7:0] <= 8'(LevelMax));

    case (cmd_e'(s_axis_tuser))
      CmdService: begin
        // Main switch: sleep once when opened without charging.
        if (closed || charging) begin
          swsleep_d = 1'b0;
        end else if (!swsleep_q) begin
          swsleep_d = 1'b1;
          sword_d   = {SaveTag, 1'b0, soc_lvl};
          sinv_d    = ~{SaveTag, 1'b0, soc_lvl};
          if (!asleep_q) begin
            asleep_d  = 1'b1;
            blanked_d = 1'b1;
          end
          pulse = 1'b1;
        end
        if (closed || !swsleep_d) begin
          if (tick) begin
            key_d = key;
            if (key && !key_q) begin
              win_d = raise_window(win_d, dwin_q);
            end
            if (win_d != '0) begin
              win_d = win_d - WindowWidth'(1);
            end
          end
          if (!startup_q) begin
            startup_d = 1'b1;
            win_d     = raise_window(win_d, swin_q);
          end
          if (win_d == '0) begin
            blanked_d = 1'b1;
          end else begin
            asleep_d = 1'b0;
            if (shown_q != soc_lvl || blanked_d) begin
              shown_d   = soc_lvl;
              blanked_d = 1'b0;
            end
          end
        end
      end
      CmdWindow: begin
        win_d = raise_window(win_q, dwin_q);
      end
      CmdPrepStop: begin
        asleep_d  = 1'b1;
        blanked_d = 1'b1;
      end
      CmdPreview: begin
        asleep_d  = 1'b0;
        blanked_d = 1'b0;
        shown_d   = valid_save ? sword_q[LevelWidth-1:0] : soc_lvl;
      end
      CmdSleep: begin
        if (!asleep_q) begin
          asleep_d  = 1'b1;
          blanked_d = 1'b1;
        end
      end
      CmdWake: begin
        asleep_d = 1'b0;
      end
      CmdSave: begin
        sword_d = {SaveTag, 1'b0, soc_lvl};
        sinv_d  = ~{SaveTag, 1'b0, soc_lvl};
      end
      default: ;
    endcase

    // Thermometer code of the shown level, dark while asleep or blanked.
    for (int i = 0; i < NumLeds; i++) begin
      mask[i] = !asleep_d && !blanked_d && (shown_d >= thr_q[i]);
    end
    active     = !asleep_d && !blanked_d && (win_d != '0);
    out_data_d = {2'b00, pulse, active, mask};
  end

  // Advance the state and load the result on each accepted request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      asleep_q    <= 1'b0;
      blanked_q   <= 1'b1;
      shown_q     <= '0;
      win_q       <= '0;
      startup_q   <= 1'b0;
      key_q       <= 1'b0;
      swsleep_q   <= 1'b0;
      sword_q     <= '0;
      sinv_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        asleep_q  <= asleep_d;
        blanked_q <= blanked_d;
        shown_q   <= shown_d;
        win_q     <= win_d;
        startup_q <= startup_d;
        key_q     <= key_d;
        swsleep_q <= swsleep_d;
        sword_q   <= sword_d;
        sinv_q    <= sinv_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload holds until the next accepted request.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

endmodule
